### hdl/rldfp_pkg.sv
// Shared types, constants and helper functions of the datagram field parser.
package rldfp_pkg;

    // Token kinds
    localparam logic [2:0] TK_NUM     = 3'd0;
    localparam logic [2:0] TK_BYTE    = 3'd1;
    localparam logic [2:0] TK_ABSENT  = 3'd2;
    localparam logic [2:0] TK_END     = 3'd3;
    localparam logic [2:0] TK_VERDICT = 3'd4;

    // Verdict / error codes
    localparam logic [2:0] E_NONE   = 3'd0;
    localparam logic [2:0] E_OTHER  = 3'd1;
    localparam logic [2:0] E_TRUNC  = 3'd2;
    localparam logic [2:0] E_MAGIC  = 3'd3;
    localparam logic [2:0] E_SCHEMA = 3'd4;
    localparam logic [2:0] E_LONG   = 3'd5;
    localparam logic [2:0] E_ZONE   = 3'd6;
    localparam logic [2:0] E_IDLE   = 3'd7;

    // Field kinds
    localparam logic [3:0] FK_MAGSCH = 4'd0;
    localparam logic [3:0] FK_TYPE   = 4'd1;
    localparam logic [3:0] FK_STR    = 4'd2;
    localparam logic [3:0] FK_OPT    = 4'd3;
    localparam logic [3:0] FK_DATE   = 4'd4;
    localparam logic [3:0] FK_U64    = 4'd5;
    localparam logic [3:0] FK_U8     = 4'd6;
    localparam logic [3:0] FK_I32    = 4'd7;
    localparam logic [3:0] FK_DONE   = 4'd8;

    // Field indexes with special sequencing
    localparam logic [5:0] FI_TYPE      = 6'd1;
    localparam logic [5:0] FI_ID        = 6'd2;
    localparam logic [5:0] FI_LOG_FIRST = 6'd3;
    localparam logic [5:0] FI_LOG_LAST  = 6'd19;
    localparam logic [5:0] FI_STS_FIRST = 6'd20;
    localparam logic [5:0] FI_STS_LAST  = 6'd32;
    localparam logic [5:0] FI_DONE      = 6'd33;

    // Message kinds
    localparam logic [1:0] MK_STATUS = 2'd1;
    localparam logic [1:0] MK_LOGGED = 2'd2;
    localparam logic [1:0] MK_OTHER  = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_MAGIC   = 2'd0;
    localparam logic [1:0] REG_MAXLEN  = 2'd1;
    localparam logic [1:0] REG_LOWSCH  = 2'd2;
    localparam logic [1:0] REG_HIGHSCH = 2'd3;

    localparam logic [31:0] MAGIC_RESET   = 32'hadbccbda;
    localparam logic [16:0] MAXLEN_RESET  = 17'd65536;
    localparam logic [7:0]  LOWSCH_RESET  = 8'd2;
    localparam logic [7:0]  HIGHSCH_RESET = 8'd3;

    localparam logic [31:0] STR_ABSENT = 32'hffffffff;
    localparam logic [63:0] JD_FIRST   = 64'd1721426;
    localparam logic [63:0] JD_LAST    = 64'd5373484;
    localparam logic [23:0] JD_EPOCH   = 24'd2440588;
    localparam logic [17:0] DAY_SEC    = 18'd86400;
    // ceil(2^38 / 1000): exact quotient by 1000 for any 32-bit value
    localparam logic [28:0] MS_RECIP   = 29'd274877907;
    localparam int          MS_SHIFT   = 38;

    localparam int SLOTS          = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [2:0]         token_kind;
        logic [5:0]         field_code;
        logic signed [63:0] token_value;
        logic [2:0]         verdict_code;
        logic               final_token;
    } out_t;

    // Tokens caused by one input byte; a date in slot 0 still needs ms/1000
    typedef struct packed {
        logic [1:0]             count;
        out_t [SLOTS-1:0]       slot;
        logic                   date_ok;
        logic [31:0]            date_ms;
    } bundle_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [16:0] max_string_length;
        logic [7:0]  lowest_schema;
        logic [7:0]  highest_schema;
    } cfg_t;

    function automatic logic [3:0] field_kind(input logic [5:0] idx);
        logic [3:0] k;
        case (idx)
            6'd0:  k = FK_MAGSCH;
            6'd1:  k = FK_TYPE;
            6'd3:  k = FK_DATE;
            6'd6:  k = FK_U64;
            6'd13: k = FK_DATE;
            6'd17: k = FK_OPT;
            6'd18: k = FK_OPT;
            6'd19: k = FK_OPT;
            6'd20: k = FK_U64;
            6'd25: k = FK_U8;
            6'd26: k = FK_U8;
            6'd27: k = FK_U8;
            6'd28: k = FK_I32;
            6'd29: k = FK_I32;
            default: begin
                if (idx >= FI_DONE) k = FK_DONE;
                else                k = FK_STR;
            end
        endcase
        return k;
    endfunction

    function automatic out_t mk_tok(input logic [2:0] kind, input logic [5:0] code,
                                    input logic [63:0] value, input logic [2:0] verdict,
                                    input logic fin);
        out_t t;
        t.token_kind   = kind;
        t.field_code   = code;
        t.token_value  = value;
        t.verdict_code = verdict;
        t.final_token  = fin;
        return t;
    endfunction

endpackage

### hdl/rldfp_front.sv
// Front end: byte-serial header and body parser that classifies bytes into token bundles.
module rldfp_front import rldfp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    s_valid,
    output logic    s_ready,
    input  in_t     s_data,
    input  logic    q_ready,
    output logic    q_push,
    output bundle_t q_data
);

    logic [5:0]  fi_reg,  fi_next;
    logic [3:0]  bif_reg, bif_next;
    logic [63:0] acc_reg, acc_next;
    logic [16:0] sl_reg,  sl_next;
    logic [1:0]  mk_reg,  mk_next;
    logic [63:0] day_reg, day_next;
    logic [31:0] ms_reg,  ms_next;
    logic [2:0]  err_reg, err_next;
    logic        oph_reg, oph_next;

    // day term, computed the cycle after the day number is captured
    logic signed [41:0] dterm_reg;
    logic               inrange_reg;
    logic signed [23:0] day_diff;

    logic accept;

    assign accept  = s_valid && q_ready;
    assign s_ready = q_ready;

    assign day_diff = $signed(day_reg[23:0] - JD_EPOCH);

    always_ff @(posedge aclk) begin
        dterm_reg   <= day_diff * $signed({1'b0, DAY_SEC});
        inrange_reg <= !day_reg[63] && (day_reg >= JD_FIRST) && (day_reg <= JD_LAST);
    end

    // Parse one byte
    always_comb begin
        logic [7:0]  b;
        logic [3:0]  k;
        logic [3:0]  width;
        logic        fin;
        logic        skip;
        logic [1:0]  nc;
        logic [31:0] off;
        logic        do_date;
        logic [2:0]  verdict;

        fi_next  = fi_reg;
        bif_next = bif_reg;
        acc_next = acc_reg;
        sl_next  = sl_reg;
        mk_next  = mk_reg;
        day_next = day_reg;
        ms_next  = ms_reg;
        err_next = err_reg;
        oph_next = oph_reg;
        q_data   = '0;
        b        = s_data.data_byte;
        fin      = 1'b0;
        skip     = 1'b0;
        nc       = 2'd0;
        off      = '0;
        do_date  = 1'b0;
        width    = 4'd8;
        verdict  = E_NONE;

        if (s_data.first_byte) begin
            fi_next  = '0;
            bif_next = '0;
            acc_next = '0;
            sl_next  = '0;
            oph_next = 1'b0;
            mk_next  = '0;
            day_next = '0;
            ms_next  = '0;
            err_next = E_NONE;
        end else if (err_reg == E_IDLE) begin
            skip = 1'b1;
        end

        k = field_kind(fi_next);

        if (!skip && err_next == E_NONE && fi_next < FI_DONE) begin
            if (k == FK_STR || k == FK_OPT) begin
                if (bif_next < 4'd4) begin
                    acc_next = {32'd0, acc_next[23:0], b};
                    bif_next = bif_next + 4'd1;
                    if (bif_next == 4'd4) begin
                        if (acc_next[31:0] == STR_ABSENT) begin
                            q_data.slot[nc] = mk_tok(TK_ABSENT, fi_next, '0, E_NONE, 1'b0);
                            nc  = nc + 2'd1;
                            fin = 1'b1;
                        end else if (acc_next[31:0] > {15'd0, cfg.max_string_length}) begin
                            if (k == FK_OPT) begin
                                q_data.slot[nc] = mk_tok(TK_ABSENT, fi_next, '0, E_NONE, 1'b0);
                                nc       = nc + 2'd1;
                                fi_next  = FI_DONE;
                                bif_next = '0;
                                acc_next = '0;
                                sl_next  = '0;
                                oph_next = 1'b0;
                            end else begin
                                err_next = E_LONG;
                            end
                        end else if (acc_next[31:0] == 32'd0) begin
                            q_data.slot[nc] = mk_tok(TK_END, fi_next, '0, E_NONE, 1'b0);
                            nc  = nc + 2'd1;
                            fin = 1'b1;
                        end else begin
                            sl_next = acc_next[16:0];
                        end
                    end
                end else begin
                    q_data.slot[nc] = mk_tok(TK_BYTE, fi_next, {56'd0, b}, E_NONE, 1'b0);
                    nc = nc + 2'd1;
                    if (sl_next != '0) sl_next = sl_next - 17'd1;
                    if (sl_next == '0) begin
                        q_data.slot[nc] = mk_tok(TK_END, fi_next, '0, E_NONE, 1'b0);
                        nc  = nc + 2'd1;
                        fin = 1'b1;
                    end
                end
            end else if (k == FK_DATE) begin
                acc_next = {acc_next[55:0], b};
                bif_next = bif_next + 4'd1;
                if (oph_next) begin
                    if (bif_next >= 4'd4) begin
                        off     = acc_next[31:0];
                        do_date = 1'b1;
                    end
                end else if (bif_next == 4'd8) begin
                    day_next = acc_next;
                    acc_next = '0;
                end else if (bif_next == 4'd12) begin
                    ms_next  = acc_next[31:0];
                    acc_next = '0;
                end else if (bif_next == 4'd13) begin
                    acc_next = '0;
                    if (b == 8'd3) begin
                        err_next = E_ZONE;
                    end else if (b == 8'd2) begin
                        oph_next = 1'b1;
                        bif_next = '0;
                    end else begin
                        do_date = 1'b1;
                    end
                end
                if (do_date) begin
                    // date is always the first token of its byte
                    q_data.slot[nc] = mk_tok(TK_NUM, fi_next,
                        inrange_reg ? ({{22{dterm_reg[41]}}, dterm_reg} -
                                       {{32{off[31]}}, off}) : 64'd0,
                        E_NONE, 1'b0);
                    q_data.date_ok = inrange_reg;
                    q_data.date_ms = ms_next;
                    nc  = nc + 2'd1;
                    fin = 1'b1;
                end
            end else if (k == FK_TYPE) begin
                ms_next  = {ms_next[23:0], b};
                bif_next = bif_next + 4'd1;
                if (bif_next == 4'd4) begin
                    if (acc_next[63:32] != cfg.magic_word) begin
                        err_next = E_MAGIC;
                    end else if (acc_next[31:0] < {24'd0, cfg.lowest_schema} ||
                                 acc_next[31:0] > {24'd0, cfg.highest_schema}) begin
                        err_next = E_SCHEMA;
                    end else begin
                        q_data.slot[nc] = mk_tok(TK_NUM, 6'd0, {32'd0, acc_next[31:0]},
                                                 E_NONE, 1'b0);
                        nc = nc + 2'd1;
                        q_data.slot[nc] = mk_tok(TK_NUM, FI_TYPE, {32'd0, ms_next},
                                                 E_NONE, 1'b0);
                        nc = nc + 2'd1;
                        if (ms_next == 32'd5)      mk_next = MK_LOGGED;
                        else if (ms_next == 32'd1) mk_next = MK_STATUS;
                        else                       mk_next = MK_OTHER;
                        ms_next  = '0;
                        fi_next  = FI_ID;
                        bif_next = '0;
                        acc_next = '0;
                        sl_next  = '0;
                        oph_next = 1'b0;
                    end
                end
            end else if (k != FK_DONE) begin
                // fixed-width big-endian numbers
                acc_next = {acc_next[55:0], b};
                bif_next = bif_next + 4'd1;
                if (k == FK_U8)       width = 4'd1;
                else if (k == FK_I32) width = 4'd4;
                else                  width = 4'd8;
                if (bif_next == width) begin
                    if (k == FK_MAGSCH) begin
                        fi_next  = FI_TYPE;
                        bif_next = '0;
                        ms_next  = '0;
                    end else begin
                        q_data.slot[nc] = mk_tok(TK_NUM, fi_next,
                            (k == FK_I32) ? {{32{acc_next[31]}}, acc_next[31:0]} : acc_next,
                            E_NONE, 1'b0);
                        nc  = nc + 2'd1;
                        fin = 1'b1;
                    end
                end
            end

            // advance to the next field
            if (fin) begin
                if (fi_next == FI_ID && mk_next != MK_LOGGED && mk_next != MK_STATUS) begin
                    err_next = E_OTHER;
                end else begin
                    if (fi_next == FI_ID)
                        fi_next = (mk_next == MK_LOGGED) ? FI_LOG_FIRST : FI_STS_FIRST;
                    else if (fi_next == FI_LOG_LAST || fi_next >= FI_STS_LAST)
                        fi_next = FI_DONE;
                    else
                        fi_next = fi_next + 6'd1;
                    bif_next = '0;
                    acc_next = '0;
                    sl_next  = '0;
                    oph_next = 1'b0;
                end
            end
        end

        // end of datagram: verdict
        if (!skip && s_data.last_byte) begin
            if (err_next != E_NONE) begin
                verdict = err_next;
            end else if (fi_next >= FI_DONE) begin
                verdict = E_NONE;
            end else if (field_kind(fi_next) == FK_OPT) begin
                if (bif_next != '0) begin
                    q_data.slot[nc] = mk_tok(TK_ABSENT, fi_next, '0, E_NONE, 1'b0);
                    nc = nc + 2'd1;
                end
                verdict = E_NONE;
            end else begin
                verdict = E_TRUNC;
            end
            q_data.slot[nc] = mk_tok(TK_VERDICT, 6'd0, '0, verdict, 1'b1);
            nc = nc + 2'd1;
            err_next = E_IDLE;
        end

        q_data.count = nc;
        q_push       = accept && (nc != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fi_reg  <= '0;
            bif_reg <= '0;
            acc_reg <= '0;
            sl_reg  <= '0;
            mk_reg  <= '0;
            day_reg <= '0;
            ms_reg  <= '0;
            err_reg <= E_NONE;
            oph_reg <= 1'b0;
        end else if (accept) begin
            fi_reg  <= fi_next;
            bif_reg <= bif_next;
            acc_reg <= acc_next;
            sl_reg  <= sl_next;
            mk_reg  <= mk_next;
            day_reg <= day_next;
            ms_reg  <= ms_next;
            err_reg <= err_next;
            oph_reg <= oph_next;
        end
    end

endmodule

### hdl/rldfp_queue.sv
// Short register queue of token bundles between the front and back ends.
module rldfp_queue import rldfp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    output logic    not_full,
    input  logic    pop,
    output logic    not_empty,
    output bundle_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t        mem_reg [DEPTH];
    logic [PW-1:0]  wr_reg, wr_next;
    logic [PW-1:0]  rd_reg, rd_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign not_full  = (cnt_reg != CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];

    // Pointer and fill count update
    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        if (pop)  rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        if (push && !pop)      cnt_next = cnt_reg + CW'(1);
        else if (pop && !push) cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### hdl/rldfp_back.sv
// Back end: splits bundles into tokens, finishes date values and drives the result channel.
module rldfp_back import rldfp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    head_valid,
    input  bundle_t head,
    output logic    pop,
    output logic    m_valid,
    input  logic    m_ready,
    output out_t    m_data
);

    logic [1:0]  sub_reg, sub_next;
    logic        s1_valid_reg;
    out_t        s1_tok_reg;
    logic        s1_date_reg;
    logic [60:0] s1_prod_reg;
    logic        s2_valid_reg;
    out_t        s2_tok_reg;
    out_t        s2_tok_next;

    logic        adv;
    logic        take;
    logic        last_sub;
    out_t        tok;

    assign adv      = !s2_valid_reg || m_ready;
    assign take     = adv && head_valid;
    assign tok      = head.slot[sub_reg];
    assign last_sub = (sub_reg == head.count - 2'd1);
    assign pop      = take && last_sub;
    assign sub_next = last_sub ? 2'd0 : sub_reg + 2'd1;

    assign m_valid = s2_valid_reg;
    assign m_data  = s2_tok_reg;

    // Stage 1: pick token, multiply milliseconds by reciprocal of 1000
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tok_reg  <= tok;
            s1_date_reg <= head.date_ok && (sub_reg == 2'd0);
            s1_prod_reg <= head.date_ms * MS_RECIP;
        end
    end

    // Stage 2: add whole seconds into the date value
    always_comb begin
        s2_tok_next = s1_tok_reg;
        if (s1_date_reg)
            s2_tok_next.token_value = s1_tok_reg.token_value +
                $signed({41'd0, s1_prod_reg[60:MS_SHIFT]});
    end

    always_ff @(posedge aclk) begin
        if (adv) s2_tok_reg <= s2_tok_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (take) sub_reg <= sub_next;
            if (adv) begin
                s1_valid_reg <= head_valid;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

endmodule

### hdl/radio_log_datagram_field_parser.sv
// Top level of the datagram field parser: register port, front end, queue and back end.
//
//   Port group   Dir  Handshake          Payload
//   s_*          in   s_valid/s_ready    in_t  (data_byte, first_byte, last_byte)
//   m_*          out  m_valid/m_ready    out_t (kind, field, value, verdict, final)
//   APB          in   psel/penable       4 registers at byte offsets 0, 4, 8, 12
//
// One byte is accepted per cycle while the bundle queue has room; a byte
// yields zero to three tokens, which leave one per cycle after a two-stage
// back end (reciprocal multiply for dates, then add), so output rate bounds
// throughput. Reset is synchronous active low and restores register defaults.
// A stalled m_ready fills the queue and then drops s_ready.
module radio_log_datagram_field_parser import rldfp_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg_reg;
    logic    q_push, q_not_full, q_not_empty, q_pop;
    bundle_t q_in, q_head;

    assign pready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_word        <= MAGIC_RESET;
            cfg_reg.max_string_length <= MAXLEN_RESET;
            cfg_reg.lowest_schema     <= LOWSCH_RESET;
            cfg_reg.highest_schema    <= HIGHSCH_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_MAGIC:   cfg_reg.magic_word        <= pwdata;
                REG_MAXLEN:  cfg_reg.max_string_length <= pwdata[16:0];
                REG_LOWSCH:  cfg_reg.lowest_schema     <= pwdata[7:0];
                REG_HIGHSCH: cfg_reg.highest_schema    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[3:2])
            REG_MAGIC:   prdata = cfg_reg.magic_word;
            REG_MAXLEN:  prdata = {15'd0, cfg_reg.max_string_length};
            REG_LOWSCH:  prdata = {24'd0, cfg_reg.lowest_schema};
            REG_HIGHSCH: prdata = {24'd0, cfg_reg.highest_schema};
            default:     prdata = '0;
        endcase
    end

    rldfp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_ready (q_not_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    rldfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    rldfp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_not_empty),
        .head       (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // A final token is always a verdict
    a_final_is_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.final_token |-> m_data.token_kind == TK_VERDICT)
        else $error("final token without verdict kind");

    // Only verdicts carry a verdict code or the final mark
    a_verdict_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_kind != TK_VERDICT |->
            m_data.verdict_code == E_NONE && !m_data.final_token)
        else $error("verdict field set on a non-verdict token");

    // Queue never receives a bundle while full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> q_not_full)
        else $error("bundle queue overflow");

    // Back end never pops an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty)
        else $error("bundle queue underflow");

endmodule

### tb/radio_log_datagram_field_parser_tb.sv
// Testbench for the datagram field parser: byte stimulus, token prediction and checking.
`timescale 1ns / 100ps

module radio_log_datagram_field_parser_tb import rldfp_pkg::*; ;

    // Predicts the token stream of the parser and checks the tokens it produces
    class token_scoreboard;
        // Register copies
        logic [31:0] magic;
        logic [16:0] maxlen;
        logic [7:0]  lowsch;
        logic [7:0]  highsch;

        // Parser state
        logic [5:0]  fidx;
        logic [3:0]  bif;
        logic [63:0] acc;
        logic [16:0] str_left;
        logic [1:0]  mkind;
        logic [63:0] day;
        logic [31:0] msec;
        logic [2:0]  err;
        logic        ophase;

        out_t expected_tokens[$];
        int   mismatches;

        function new();
            magic   = 32'hadbccbda;
            maxlen  = 17'd65536;
            lowsch  = 8'd2;
            highsch = 8'd3;
            mismatches = 0;
            clear_parse();
        endfunction

        function void set_reg(int idx, logic [31:0] v);
            case (idx)
                REG_MAGIC:   magic   = v;
                REG_MAXLEN:  maxlen  = v[16:0];
                REG_LOWSCH:  lowsch  = v[7:0];
                REG_HIGHSCH: highsch = v[7:0];
                default: ;
            endcase
        endfunction

        function logic [3:0] kind_at(logic [5:0] i);
            if (i >= FI_DONE) return FK_DONE;
            if (i == 0) return FK_MAGSCH;
            if (i == FI_TYPE) return FK_TYPE;
            if (i == 3 || i == 13) return FK_DATE;
            if (i == 6 || i == 20) return FK_U64;
            if (i >= 17 && i <= 19) return FK_OPT;
            if (i >= 25 && i <= 27) return FK_U8;
            if (i == 28 || i == 29) return FK_I32;
            return FK_STR;
        endfunction

        function void push(logic [2:0] k, logic [5:0] c, logic [63:0] v,
                           logic [2:0] vd = E_NONE, logic f = 1'b0);
            out_t t;
            t.token_kind   = k;
            t.field_code   = c;
            t.token_value  = v;
            t.verdict_code = vd;
            t.final_token  = f;
            expected_tokens.push_back(t);
        endfunction

        function void begin_field(logic [5:0] i);
            fidx     = i;
            bif      = 0;
            acc      = 0;
            str_left = 0;
            ophase   = 0;
        endfunction

        function void clear_parse();
            begin_field(6'd0);
            mkind = 0;
            day   = 0;
            msec  = 0;
            err   = E_NONE;
        endfunction

        function void finish_field();
            if (fidx == FI_ID) begin
                if (mkind == MK_LOGGED)      begin_field(FI_LOG_FIRST);
                else if (mkind == MK_STATUS) begin_field(FI_STS_FIRST);
                else                         err = E_OTHER;
            end else if (fidx == FI_LOG_LAST || fidx >= FI_STS_LAST) begin
                begin_field(FI_DONE);
            end else begin
                begin_field(6'(fidx + 6'd1));
            end
        endfunction

        // Unix seconds of the date held in day/msec, zero outside years 1..9999
        function logic [63:0] unix_secs(logic [31:0] offv);
            longint jd, s, off;
            if (day[63]) return 64'd0;
            if (day < 64'd1721426 || day > 64'd5373484) return 64'd0;
            jd  = day;
            off = $signed(offv);
            s   = (jd - 64'sd2440588) * 64'sd86400 + longint'({32'b0, msec / 32'd1000}) - off;
            return s;
        endfunction

        function void date_byte(logic [7:0] b);
            acc = (acc << 8) | {56'd0, b};
            bif++;
            if (ophase) begin
                if (bif < 4) return;
                push(TK_NUM, fidx, unix_secs(acc[31:0]));
                finish_field();
                return;
            end
            if (bif == 8) begin
                day = acc;
                acc = 0;
            end else if (bif == 12) begin
                msec = acc[31:0];
                acc  = 0;
            end else if (bif == 13) begin
                acc = 0;
                if (b == 3) begin
                    err = E_ZONE;
                end else if (b == 2) begin
                    ophase = 1;
                    bif    = 0;
                end else begin
                    push(TK_NUM, fidx, unix_secs(32'd0));
                    finish_field();
                end
            end
        endfunction

        function void string_byte(logic [7:0] b, bit opt);
            if (bif < 4) begin
                acc = ((acc << 8) | {56'd0, b}) & 64'hffffffff;
                bif++;
                if (bif < 4) return;
                if (acc == 64'hffffffff) begin
                    push(TK_ABSENT, fidx, 64'd0);
                    finish_field();
                end else if (acc > {47'd0, maxlen}) begin
                    if (opt) begin
                        push(TK_ABSENT, fidx, 64'd0);
                        begin_field(FI_DONE);
                    end else begin
                        err = E_LONG;
                    end
                end else if (acc == 0) begin
                    push(TK_END, fidx, 64'd0);
                    finish_field();
                end else begin
                    str_left = acc[16:0];
                end
                return;
            end
            push(TK_BYTE, fidx, {56'b0, b});
            if (str_left > 0) str_left--;
            if (str_left == 0) begin
                push(TK_END, fidx, 64'd0);
                finish_field();
            end
        endfunction

        function void field_byte(logic [7:0] b);
            logic [3:0] k;
            int w;
            k = kind_at(fidx);
            if (k == FK_STR || k == FK_OPT) begin
                string_byte(b, k == FK_OPT);
            end else if (k == FK_DATE) begin
                date_byte(b);
            end else if (k == FK_TYPE) begin
                msec = (msec << 8) | {24'd0, b};
                bif++;
                if (bif == 4) begin
                    if (acc[63:32] != magic) begin
                        err = E_MAGIC;
                    end else if (acc[31:0] < {24'd0, lowsch} ||
                                 acc[31:0] > {24'd0, highsch}) begin
                        err = E_SCHEMA;
                    end else begin
                        push(TK_NUM, 6'd0, {32'b0, acc[31:0]});
                        push(TK_NUM, FI_TYPE, {32'b0, msec});
                        mkind = msec == 5 ? MK_LOGGED : (msec == 1 ? MK_STATUS : MK_OTHER);
                        msec  = 0;
                        begin_field(FI_ID);
                    end
                end
            end else if (k != FK_DONE) begin
                acc = (acc << 8) | {56'd0, b};
                bif++;
                w = k == FK_U8 ? 1 : (k == FK_I32 ? 4 : 8);
                if (bif < w) return;
                if (k == FK_MAGSCH) begin
                    fidx = FI_TYPE;
                    bif  = 0;
                    msec = 0;
                    return;
                end
                push(TK_NUM, fidx, k == FK_I32 ? {{32{acc[31]}}, acc[31:0]} : acc);
                finish_field();
            end
        endfunction

        // Notes one accepted request and queues the tokens it causes
        function void note_byte(in_t r);
            logic [2:0] vd;
            if (r.first_byte) clear_parse();
            else if (err == E_IDLE) return;
            if (err == E_NONE && fidx < FI_DONE) field_byte(r.data_byte);
            if (r.last_byte) begin
                if (err != E_NONE) begin
                    vd = err;
                end else if (fidx >= FI_DONE) begin
                    vd = E_NONE;
                end else if (kind_at(fidx) == FK_OPT) begin
                    if (bif > 0) push(TK_ABSENT, fidx, 64'd0);
                    vd = E_NONE;
                end else begin
                    vd = E_TRUNC;
                end
                push(TK_VERDICT, 6'd0, 64'd0, vd, 1'b1);
                err = E_IDLE;
            end
        endfunction

        // Compares one produced token with the oldest expected one
        function void check_token(out_t got);
            out_t want;
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token: kind %0d field %0d value %h verdict %0d final %0d",
                             got.token_kind, got.field_code, got.token_value,
                             got.verdict_code, got.final_token);
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_kind !== want.token_kind || got.field_code !== want.field_code ||
                got.token_value !== want.token_value ||
                got.verdict_code !== want.verdict_code ||
                got.final_token !== want.final_token) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("token mismatch: expected %0d/%0d/%h/%0d/%0d got %0d/%0d/%h/%0d/%0d",
                             want.token_kind, want.field_code, want.token_value,
                             want.verdict_code, want.final_token,
                             got.token_kind, got.field_code, got.token_value,
                             got.verdict_code, got.final_token);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 24;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    token_scoreboard sb;
    logic [7:0] dgram[$];
    int sender_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int cycles;
    int sent_bytes;

    radio_log_datagram_field_parser u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random stalls, or a long counted hold-off when requested
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready = 1'b0;
            hold_cycles--;
        end else begin
            m_ready = $urandom_range(99, 0) >= recv_stall_pct;
        end
    end

    // Token monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_token(m_data);
    end

    task automatic reg_write(int idx, logic [31:0] v);
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = 4'(4 * idx);
        pwdata  = v;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        sb.set_reg(idx, v);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Sends one byte request, with random sender gaps beforehand
    task automatic send_byte(logic [7:0] b, logic f, logic l);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data.data_byte  = b;
        s_data.first_byte = f;
        s_data.last_byte  = l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(s_data);
        sent_bytes++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Sends the built datagram, cut to len bytes (0 means whole)
    task automatic send_dgram(int len = 0, bit mark_first = 1);
        int n;
        n = (len == 0 || len > dgram.size()) ? dgram.size() : len;
        for (int i = 0; i < n; i++)
            send_byte(dgram[i], mark_first && i == 0, i == n - 1);
        dgram.delete();
    endtask

    task automatic wait_idle();
        while (sb.expected_tokens.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic void put_n(logic [63:0] v, int nbytes);
        for (int i = nbytes - 1; i >= 0; i--) dgram.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_str(int len = -1);
        if (len < 0) len = ($urandom_range(9, 0) < 2) ? -2 : int'($urandom_range(3, 0));
        if (len == -2) begin
            put_n(64'hffffffff, 4);
            return;
        end
        put_n(64'(len), 4);
        for (int i = 0; i < len && i < 8; i++) dgram.push_back(8'($urandom_range(255, 0)));
    endfunction

    function automatic void put_date(int spec = -1);
        logic [63:0] d;
        case ($urandom_range(7, 0))
            0: d = 64'd1721426;
            1: d = 64'd5373484;
            2: d = 64'd1721425;
            3: d = 64'd5373485;
            4: d = {$urandom, $urandom};
            default: d = 64'($urandom_range(5373484, 1721426));
        endcase
        put_n(d, 8);
        put_n(64'($urandom), 4);
        if (spec < 0) begin
            case ($urandom_range(9, 0))
                0, 1, 2: spec = 2;
                3:       spec = 3;
                4:       spec = int'($urandom_range(255, 0));
                default: spec = int'($urandom_range(1, 0));
            endcase
        end
        dgram.push_back(8'(spec));
        if (spec == 2) put_n(64'($urandom), 4);
    endfunction

    function automatic logic [7:0] good_schema();
        if (sb.lowsch > sb.highsch) return sb.lowsch;
        return 8'($urandom_range(sb.highsch, sb.lowsch));
    endfunction

    function automatic void put_header(logic [31:0] typ);
        put_n(64'(sb.magic), 4);
        put_n(64'(good_schema()), 4);
        put_n(64'(typ), 4);
        put_str();
    endfunction

    // Logged record with opt_n trailing optional strings
    function automatic void build_logged(int opt_n);
        put_header(32'd5);
        put_date();
        put_str();
        put_str();
        put_n({$urandom, $urandom}, 8);
        repeat (6) put_str();
        put_date();
        repeat (3) put_str();
        repeat (opt_n) put_str();
    endfunction

    function automatic void build_status();
        put_header(32'd1);
        put_n({$urandom, $urandom}, 8);
        repeat (4) put_str();
        repeat (3) dgram.push_back(8'($urandom_range(255, 0)));
        put_n(64'($urandom), 4);
        put_n(64'($urandom), 4);
        repeat (3) put_str();
    endfunction

    // One random datagram, mostly well formed
    task automatic random_dgram();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 45) begin
            build_status();
        end else if (pick < 70) begin
            build_logged($urandom_range(3, 0));
        end else if (pick < 80) begin
            put_header($urandom);
            repeat ($urandom_range(3, 0)) dgram.push_back(8'($urandom_range(255, 0)));
        end else if (pick < 88) begin
            put_n($urandom_range(1, 0) ? 64'($urandom) : 64'(sb.magic), 4);
            put_n(64'($urandom), 4);
            put_n(64'($urandom_range(5, 0)), 4);
            put_str();
        end else begin
            repeat ($urandom_range(12, 1)) dgram.push_back(8'($urandom_range(255, 0)));
        end
        if ($urandom_range(9, 0) < 2) repeat ($urandom_range(3, 1))
            dgram.push_back(8'($urandom_range(255, 0)));
        if ($urandom_range(9, 0) < 3) send_dgram(int'($urandom_range(dgram.size(), 1)));
        else                          send_dgram();
        // stray bytes after the verdict are ignored
        if ($urandom_range(9, 0) == 0) send_byte(8'($urandom_range(255, 0)), 1'b0,
                                                 1'($urandom_range(1, 0)));
    endtask

    task automatic random_phase(int idle_pct, int stall_pct, int nbytes);
        int start;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        start = sent_bytes;
        while (sent_bytes - start < nbytes) random_dgram();
        wait_idle();
    endtask

    initial begin
        sb = new();
        cycles = 0;
        sent_bytes = 0;
        hold_cycles = 0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: first datagram after reset without a start mark, other type
        put_header(32'd7);
        dgram.push_back(8'h00);
        send_dgram(0, 0);
        // full logged record, one fixed-offset and one plain date, last optional string cut in its body
        put_header(32'd5);
        put_date(2);
        put_str(2);
        put_str(-2);
        put_n(64'hffffffffffffffff, 8);
        repeat (6) put_str(1);
        put_date(0);
        repeat (3) put_str(0);
        put_str(3);
        put_str(-2);
        put_n(64'd5, 4);
        dgram.push_back(8'h41);
        send_dgram();
        // bad magic, bad schema
        put_n(64'(~sb.magic), 4);
        put_n(64'd2, 4);
        put_n(64'd1, 4);
        send_dgram();
        put_n(64'(sb.magic), 4);
        put_n(64'd4, 4);
        put_n(64'd1, 4);
        send_dgram();
        // time-zone date spec is an error
        put_n(64'(sb.magic), 4);
        put_n(64'd3, 4);
        put_n(64'd5, 4);
        put_str(0);
        put_date(3);
        send_dgram();
        // truncated inside the header, one-byte datagram, stray bytes
        put_n(64'(sb.magic), 4);
        put_n(64'd2, 4);
        send_dgram(7);
        send_byte(8'hff, 1'b1, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b1);
        wait_idle();

        // Random phases under several register settings
        hold_cycles = 300;
        random_phase(0, 0, 15);
        reg_write(REG_MAGIC, 32'h00000000);
        reg_write(REG_MAXLEN, 32'd0);
        reg_write(REG_LOWSCH, 32'd0);
        reg_write(REG_HIGHSCH, 32'd255);
        random_phase(58, 0, 15);
        reg_write(REG_MAGIC, 32'hffffffff);
        reg_write(REG_MAXLEN, 32'd2);
        reg_write(REG_LOWSCH, 32'd255);
        random_phase(0, 58, 15);
        reg_write(REG_MAGIC, $urandom);
        reg_write(REG_MAXLEN, 32'd65536);
        reg_write(REG_LOWSCH, 32'd7);
        reg_write(REG_HIGHSCH, 32'd9);
        random_phase(29, 29, 15);

        if (sb.mismatches == 0 && sb.expected_tokens.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
